>>> hdl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, register indexes and the microcode table of the cascade
// pid controller.
// ----------------------------------------------------------------------------
package cpc_pkg;

   // field and accumulator widths
   localparam int SAMPLE_W = 16;
   localparam int ERR_W    = 17;
   localparam int DERR_W   = 18;
   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 23;
   localparam int INTEG_W  = 24;
   localparam int PROD_W   = 35;
   localparam int ACC_W    = 36;
   localparam int FRAC_W   = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 23;

   // width of the microprogram step index
   localparam int STEP_W = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_KP  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_KI  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_KD  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_LIM = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_KP  = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_KI  = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_KD  = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LIM = 8'd7;

   // alu operation of one step
   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_ERR,
      ALU_INT_ADD,
      ALU_INT_CLAMP,
      ALU_ACC_ADD,
      ALU_OUT
   } alu_op_type;

   // multiplier operand selects
   typedef enum logic {
      OPND_ERR,
      OPND_DERR
   } opnd_sel_type;

   typedef enum logic [1:0] {
      GAIN_P,
      GAIN_I,
      GAIN_D
   } gain_sel_type;

   // sequencer state
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // one control word
   typedef struct packed {
      alu_op_type   alu;
      logic         mul_en;
      opnd_sel_type a_sel;
      gain_sel_type g_sel;
      logic         branch;
   } ucode_type;

   // control from sequencer to datapath
   typedef struct packed {
      logic      load;
      logic      issue;
      logic      loop_inner;
      ucode_type cw;
   } ctrl_type;

   // microprogram for one pid loop; branch ends the body
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type cw;
      cw = '{alu: ALU_NOP, mul_en: 1'b0, a_sel: OPND_ERR, g_sel: GAIN_P, branch: 1'b0};
      case (step)
         3'd0: cw.alu = ALU_ERR;
         3'd1: begin
            cw.mul_en = 1'b1;
            cw.g_sel  = GAIN_I;
         end
         3'd2: begin
            cw.alu    = ALU_INT_ADD;
            cw.mul_en = 1'b1;
            cw.g_sel  = GAIN_P;
         end
         3'd3: cw.alu = ALU_INT_CLAMP;
         3'd4: begin
            cw.alu    = ALU_ACC_ADD;
            cw.mul_en = 1'b1;
            cw.a_sel  = OPND_DERR;
            cw.g_sel  = GAIN_D;
         end
         3'd5: cw.alu = ALU_ACC_ADD;
         3'd6: begin
            cw.alu    = ALU_OUT;
            cw.branch = 1'b1;
         end
         default: cw.branch = 1'b1;
      endcase
      return cw;
   endfunction

endpackage

>>> hdl/cpc_sequencer.sv
// ----------------------------------------------------------------------------
// cpc_sequencer
// Step counter, microcode fetch, loop select and transaction handshakes.
// ----------------------------------------------------------------------------
module cpc_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpc_pkg::ctrl_type ctrl
);
   import cpc_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              loop_ff, loop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ucode_type         cw;
   logic              stall;
   logic              issue;
   logic              req_fire;
   logic              finish;

   // fetch and issue control
   always_comb begin
      cw       = ucode_rom(step_ff);
      req_fire = req_valid && (state_ff == SEQ_IDLE);
      // the final step waits for the result register to free up
      stall    = cw.branch && loop_ff && rsp_valid_ff && !rsp_ready;
      issue    = (state_ff == SEQ_RUN) && !stall;
      finish   = issue && cw.branch && loop_ff;
   end

   // next state, step and loop select
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      loop_in  = loop_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               state_in = SEQ_RUN;
               step_in  = '0;
               loop_in  = 1'b0;
            end
         end
         SEQ_RUN: begin
            if (issue) begin
               if (cw.branch) begin
                  // conditional jump: outer body loops back for the inner pass
                  if (!loop_ff) begin
                     step_in = '0;
                     loop_in = 1'b1;
                  end else begin
                     state_in = SEQ_IDLE;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || finish;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         step_ff      <= '0;
         loop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         loop_ff      <= loop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // outputs
   assign req_ready       = (state_ff == SEQ_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign ctrl.load       = req_fire;
   assign ctrl.issue      = issue;
   assign ctrl.loop_inner = loop_ff;
   assign ctrl.cw         = cw;

endmodule

>>> hdl/cpc_datapath.sv
// ----------------------------------------------------------------------------
// cpc_datapath
// Configuration registers, loop state, shared multiplier and accumulator
// driven by the control word.
// ----------------------------------------------------------------------------
module cpc_datapath #(
   parameter int OUTER_OUT_LIMIT = 32767,
   parameter int INNER_OUT_LIMIT = 32767
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cpc_pkg::ctrl_type                   ctrl,
   input  logic signed [cpc_pkg::SAMPLE_W-1:0] req_outer_target,
   input  logic signed [cpc_pkg::SAMPLE_W-1:0] req_outer_measure,
   input  logic signed [cpc_pkg::SAMPLE_W-1:0] req_inner_measure,
   output logic signed [cpc_pkg::SAMPLE_W-1:0] rsp_drive,
   output logic signed [cpc_pkg::SAMPLE_W-1:0] rsp_outer_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import cpc_pkg::*;

   localparam int SUM_W = ACC_W - FRAC_W;
   localparam logic signed [SUM_W-1:0] OUTER_LIM_S = SUM_W'(OUTER_OUT_LIMIT);
   localparam logic signed [SUM_W-1:0] INNER_LIM_S = SUM_W'(INNER_OUT_LIMIT);

   // configuration
   logic [GAIN_W-1:0] okp_ff, oki_ff, okd_ff, ikp_ff, iki_ff, ikd_ff;
   logic [LIM_W-1:0]  olim_ff, ilim_ff;

   // latched samples and loop state
   logic signed [SAMPLE_W-1:0] tgt_ff, omeas_ff, imeas_ff;
   logic signed [SAMPLE_W-1:0] odrive_ff, odrive_in;
   logic signed [SAMPLE_W-1:0] rsp_drive_ff, rsp_odrive_ff;
   logic signed [ERR_W-1:0]    oprev_ff, iprev_ff;
   logic signed [INTEG_W-1:0]  ointeg_ff, iinteg_ff;

   // working registers
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [DERR_W-1:0] derr_ff, derr_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [SAMPLE_W-1:0] ref_s, meas_s;
   logic signed [ERR_W-1:0]    prev_s;
   logic signed [INTEG_W-1:0]  integ_s;
   logic [LIM_W-1:0]           lim_s;
   logic signed [ACC_W-1:0]    lim_pos, lim_neg, clamped;
   logic signed [DERR_W-1:0]   mul_a;
   logic [GAIN_W-1:0]          gain;
   logic signed [GAIN_W:0]     mul_b;
   logic signed [SUM_W-1:0]    sum_fl, out_lim, out_clamped;
   logic signed [ACC_W-1:0]    prod_ext;
   logic                       csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   // configuration writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         okp_ff  <= '0;
         oki_ff  <= '0;
         okd_ff  <= '0;
         olim_ff <= '0;
         ikp_ff  <= '0;
         iki_ff  <= '0;
         ikd_ff  <= '0;
         ilim_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_OUTER_KP:  okp_ff  <= csr_data[GAIN_W-1:0];
            CSR_OUTER_KI:  oki_ff  <= csr_data[GAIN_W-1:0];
            CSR_OUTER_KD:  okd_ff  <= csr_data[GAIN_W-1:0];
            CSR_OUTER_LIM: olim_ff <= csr_data[LIM_W-1:0];
            CSR_INNER_KP:  ikp_ff  <= csr_data[GAIN_W-1:0];
            CSR_INNER_KI:  iki_ff  <= csr_data[GAIN_W-1:0];
            CSR_INNER_KD:  ikd_ff  <= csr_data[GAIN_W-1:0];
            CSR_INNER_LIM: ilim_ff <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // per-loop operand selection
   always_comb begin
      ref_s   = ctrl.loop_inner ? odrive_ff : tgt_ff;
      meas_s  = ctrl.loop_inner ? imeas_ff  : omeas_ff;
      prev_s  = ctrl.loop_inner ? iprev_ff  : oprev_ff;
      integ_s = ctrl.loop_inner ? iinteg_ff : ointeg_ff;
      lim_s   = ctrl.loop_inner ? ilim_ff   : olim_ff;
      out_lim = ctrl.loop_inner ? INNER_LIM_S : OUTER_LIM_S;
      case (ctrl.cw.g_sel)
         GAIN_P:  gain = ctrl.loop_inner ? ikp_ff : okp_ff;
         GAIN_I:  gain = ctrl.loop_inner ? iki_ff : oki_ff;
         GAIN_D:  gain = ctrl.loop_inner ? ikd_ff : okd_ff;
         default: gain = '0;
      endcase
   end

   // error and error difference
   assign err_in  = ERR_W'(ref_s) - ERR_W'(meas_s);
   assign derr_in = DERR_W'(err_in) - DERR_W'(prev_s);

   // shared multiplier, gain is unsigned q8.8
   assign mul_a   = (ctrl.cw.a_sel == OPND_DERR) ? derr_ff : DERR_W'(err_ff);
   assign mul_b   = $signed({1'b0, gain});
   assign prod_in = PROD_W'(mul_a * mul_b);

   // integral clamp and output floor/clamp
   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      lim_pos  = $signed({{(ACC_W-LIM_W){1'b0}}, lim_s});
      lim_neg  = -lim_pos;
      if (acc_ff > lim_pos)      clamped = lim_pos;
      else if (acc_ff < lim_neg) clamped = lim_neg;
      else                       clamped = acc_ff;
      // dropping the fraction bits floors toward minus infinity
      sum_fl = acc_ff[ACC_W-1:FRAC_W];
      if (sum_fl > out_lim)       out_clamped = out_lim;
      else if (sum_fl < -out_lim) out_clamped = -out_lim;
      else                        out_clamped = sum_fl;
      odrive_in = out_clamped[SAMPLE_W-1:0];
   end

   // accumulator next value
   always_comb begin
      acc_in = acc_ff;
      case (ctrl.cw.alu)
         ALU_INT_ADD:   acc_in = ACC_W'(integ_s) + prod_ext;
         ALU_INT_CLAMP: acc_in = clamped;
         ALU_ACC_ADD:   acc_in = acc_ff + prod_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   // sample capture and working registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         tgt_ff   <= req_outer_target;
         omeas_ff <= req_outer_measure;
         imeas_ff <= req_inner_measure;
      end
      if (ctrl.issue) begin
         if (ctrl.cw.alu == ALU_ERR) begin
            err_ff  <= err_in;
            derr_ff <= derr_in;
         end
         if (ctrl.cw.mul_en) prod_ff <= prod_in;
         acc_ff <= acc_in;
         if (ctrl.cw.alu == ALU_OUT) begin
            if (ctrl.loop_inner) begin
               rsp_drive_ff  <= odrive_in;
               rsp_odrive_ff <= odrive_ff;
            end else begin
               odrive_ff <= odrive_in;
            end
         end
      end
   end

   // loop state: previous error and clamped integral
   always_ff @(posedge clock) begin
      if (reset) begin
         oprev_ff  <= '0;
         iprev_ff  <= '0;
         ointeg_ff <= '0;
         iinteg_ff <= '0;
      end else if (ctrl.issue) begin
         if (ctrl.cw.alu == ALU_ERR) begin
            if (ctrl.loop_inner) iprev_ff <= err_in;
            else                 oprev_ff <= err_in;
         end
         if (ctrl.cw.alu == ALU_INT_CLAMP) begin
            if (ctrl.loop_inner) iinteg_ff <= clamped[INTEG_W-1:0];
            else                 ointeg_ff <= clamped[INTEG_W-1:0];
         end
      end
   end

   assign rsp_drive       = rsp_drive_ff;
   assign rsp_outer_drive = rsp_odrive_ff;

endmodule

>>> hdl/cascade_pid_controller_top.sv
// ----------------------------------------------------------------------------
// cascade_pid_controller_top
// Two fixed-point pid loops in series with integral clamp.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one transaction of outer target, outer and inner
//          measurement (signed 16 bit). rsp_* returns the inner drive and the
//          outer drive used as inner reference, one transaction per request.
//   csr_*  writes gains (q8.8) and integral limits by register index; it is
//          always ready, and should be used only while no request is in
//          flight. Unknown indexes are ignored.
//   Each request runs a 7-step microprogram twice on one shared 18x17
//   multiplier and accumulator. rsp_valid and req_ready come up together
//   when the inner pass finishes, so the response can be taken and the
//   next request accepted in the same cycle; no request is accepted
//   while the previous one is still running its passes.
//   The result register frees the sequencer: a new request is accepted while
//   a response waits. If rsp_ready stays low, the next request stalls on its
//   final step until the previous response is taken.
//   Reset clears gains, limits, integrals and previous errors to zero and
//   leaves req_ready high and rsp_valid low.
// ----------------------------------------------------------------------------
module cascade_pid_controller_top #(
   parameter int OUTER_OUT_LIMIT = 32767,
   parameter int INNER_OUT_LIMIT = 32767
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cpc_pkg::SAMPLE_W-1:0] req_outer_target,
   input  logic signed [cpc_pkg::SAMPLE_W-1:0] req_outer_measure,
   input  logic signed [cpc_pkg::SAMPLE_W-1:0] req_inner_measure,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cpc_pkg::SAMPLE_W-1:0] rsp_drive,
   output logic signed [cpc_pkg::SAMPLE_W-1:0] rsp_outer_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import cpc_pkg::*;

   ctrl_type ctrl;

   // microcode sequencer
   cpc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // arithmetic datapath
   cpc_datapath #(
      .OUTER_OUT_LIMIT (OUTER_OUT_LIMIT),
      .INNER_OUT_LIMIT (INNER_OUT_LIMIT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_outer_target  (req_outer_target),
      .req_outer_measure (req_outer_measure),
      .req_inner_measure (req_inner_measure),
      .rsp_drive         (rsp_drive),
      .rsp_outer_drive   (rsp_outer_drive),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

endmodule

>>> hdl/cpc_checker.sv
// ----------------------------------------------------------------------------
// cpc_checker
// Port-level checks of the cascade pid controller, bound to the top level.
// ----------------------------------------------------------------------------
module cpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [cpc_pkg::SAMPLE_W-1:0] rsp_drive,
   input logic signed [cpc_pkg::SAMPLE_W-1:0] rsp_outer_drive
);
   import cpc_pkg::*;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_outer_drive))
      else $error("response changed while stalled");

   // drives never reach the most negative code after the clamp
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive != 16'sh8000) && (rsp_outer_drive != 16'sh8000))
      else $error("response outside clamp range");

   // an accepted transaction keeps the sequencer busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // clean start after reset
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind cascade_pid_controller_top cpc_checker u_cpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_drive       (rsp_drive),
   .rsp_outer_drive (rsp_outer_drive)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the cascade pid controller. Directed sequences cover reset
// state, output saturation, floor rounding, integral clamping and the widest
// products. Random traffic then runs through several gain settings. A local
// fixed-point predictor computes both drives of every accepted request, and
// each response is compared in order while both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import cpc_pkg::*;

   localparam int OUTER_LIMIT    = 32767;
   localparam int INNER_LIMIT    = 32767;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_ITEMS    = 100;
   localparam int MAX_REPORTS    = 10;

   localparam logic [GAIN_W-1:0] ZERO_GAIN  = 16'h0000;
   localparam logic [GAIN_W-1:0] HALF_GAIN  = 16'h0080;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h0100;
   localparam logic [GAIN_W-1:0] MAX_GAIN   = 16'hffff;
   localparam logic [LIM_W-1:0]  ZERO_LIM   = 23'h000000;
   localparam logic [LIM_W-1:0]  MAX_LIM    = 23'h7fffff;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum int {
      LOOP_OUTER = 0,
      LOOP_INNER = 1
   } loop_sel_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
      logic [LIM_W-1:0]  lim;
   } loop_gains_type;

   typedef struct packed {
      sample_type drive;
      sample_type outer_drive;
   } drive_pair_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // dut ports
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   sample_type            req_outer_target  = '0;
   sample_type            req_outer_measure = '0;
   sample_type            req_inner_measure = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   sample_type            rsp_drive;
   sample_type            rsp_outer_drive;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0] csr_data          = '0;

   // predictor state: gains, limits, previous errors and integrals per loop
   logic [GAIN_W-1:0] kp_q[2];
   logic [GAIN_W-1:0] ki_q[2];
   logic [GAIN_W-1:0] kd_q[2];
   logic [LIM_W-1:0]  int_lim_q[2];
   longint            prev_err_q[2];
   longint            integ_q[2];

   drive_pair_type expected_drives[$];
   int             mismatch_count = 0;
   int             idle_cycles    = 0;
   int             rsp_stall_left = 0;
   bit             stall_on       = 1'b1;

   cascade_pid_controller_top #(
      .OUTER_OUT_LIMIT (OUTER_LIMIT),
      .INNER_OUT_LIMIT (INNER_LIMIT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_outer_target  (req_outer_target),
      .req_outer_measure (req_outer_measure),
      .req_inner_measure (req_inner_measure),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_outer_drive   (rsp_outer_drive),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic longint clamp_mag(longint v, longint mag);
      if (v > mag) return mag;
      if (v < -mag) return -mag;
      return v;
   endfunction

   // one pid update on the selected loop; sums carry 8 fraction bits
   function automatic longint run_pid(loop_sel_type lp, longint setpoint, longint meas,
                                      longint out_lim);
      longint err;
      longint sum;
      err = setpoint - meas;
      integ_q[lp] = clamp_mag(integ_q[lp] + err * longint'(ki_q[lp]),
                              longint'(int_lim_q[lp]));
      sum = err * longint'(kp_q[lp]) + (err - prev_err_q[lp]) * longint'(kd_q[lp])
            + integ_q[lp];
      prev_err_q[lp] = err;
      // arithmetic shift floors toward minus infinity
      return clamp_mag(sum >>> FRAC_W, out_lim);
   endfunction

   function automatic drive_pair_type predict_drives(sample_type target, sample_type omeas,
                                                     sample_type imeas);
      drive_pair_type res;
      longint         outer_out;
      outer_out       = run_pid(LOOP_OUTER, longint'(target), longint'(omeas), OUTER_LIMIT);
      res.outer_drive = sample_type'(outer_out);
      res.drive       = sample_type'(run_pid(LOOP_INNER, outer_out, longint'(imeas),
                                             INNER_LIMIT));
      return res;
   endfunction

   // register write as seen by the predictor; unknown indexes are dropped
   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_OUTER_KP:  kp_q[LOOP_OUTER]      = data[GAIN_W-1:0];
         CSR_OUTER_KI:  ki_q[LOOP_OUTER]      = data[GAIN_W-1:0];
         CSR_OUTER_KD:  kd_q[LOOP_OUTER]      = data[GAIN_W-1:0];
         CSR_OUTER_LIM: int_lim_q[LOOP_OUTER] = data[LIM_W-1:0];
         CSR_INNER_KP:  kp_q[LOOP_INNER]      = data[GAIN_W-1:0];
         CSR_INNER_KI:  ki_q[LOOP_INNER]      = data[GAIN_W-1:0];
         CSR_INNER_KD:  kd_q[LOOP_INNER]      = data[GAIN_W-1:0];
         CSR_INNER_LIM: int_lim_q[LOOP_INNER] = data[LIM_W-1:0];
         default: ;
      endcase
   endfunction

   initial begin
      for (int i = 0; i < 2; i++) begin
         kp_q[i]       = '0;
         ki_q[i]       = '0;
         kd_q[i]       = '0;
         int_lim_q[i]  = '0;
         prev_err_q[i] = 0;
         integ_q[i]    = 0;
      end
   end

   // ------------------------------------------------------------------------
   // random helpers
   // ------------------------------------------------------------------------

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!stall_on) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // saturate to the signed sample range
   function automatic sample_type sat_sample(longint v);
      if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return sample_type'(v);
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic sample_type near_sample(sample_type base);
      return sat_sample(longint'(base) + longint'($urandom_range(512)) - 256);
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(5))
         0: return ZERO_GAIN;
         1: return GAIN_W'($urandom_range(32'h0040));
         2: return GAIN_W'($urandom_range(32'h0200));
         3: return GAIN_W'($urandom_range(32'h2000));
         4: return GAIN_W'($urandom);
         default: return MAX_GAIN;
      endcase
   endfunction

   function automatic logic [LIM_W-1:0] rand_limit();
      case ($urandom_range(4))
         0: return ZERO_LIM;
         1: return LIM_W'($urandom_range(32'h4000));
         2: return LIM_W'($urandom_range(32'h80_0000));
         3: return LIM_W'($urandom);
         default: return MAX_LIM;
      endcase
   endfunction

   function automatic loop_gains_type rand_loop();
      loop_gains_type g;
      g.kp  = rand_gain();
      g.ki  = rand_gain();
      g.kd  = rand_gain();
      g.lim = rand_limit();
      return g;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus tasks
   // ------------------------------------------------------------------------

   task automatic note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // one request transaction; valid stays up across back-to-back requests
   task automatic send_sample(sample_type target, sample_type omeas, sample_type imeas);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_outer_target  <= target;
      req_outer_measure <= omeas;
      req_inner_measure <= imeas;
      do @(posedge clock); while (!req_ready);
      expected_drives.push_back(predict_drives(target, omeas, imeas));
   endtask

   task automatic wait_results_drained();
      if (req_valid) req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   // gains get random junk above bit 15 so the width masking is exercised
   task automatic reconfigure(loop_gains_type og, loop_gains_type ig);
      logic [CSR_IDX_W-1:0] stray_idx;
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_OUTER_KP,  {7'($urandom), og.kp});
      write_csr(CSR_OUTER_KI,  {7'($urandom), og.ki});
      write_csr(CSR_OUTER_KD,  {7'($urandom), og.kd});
      write_csr(CSR_OUTER_LIM, og.lim);
      write_csr(CSR_INNER_KP,  {7'($urandom), ig.kp});
      write_csr(CSR_INNER_KI,  {7'($urandom), ig.ki});
      write_csr(CSR_INNER_KD,  {7'($urandom), ig.kd});
      write_csr(CSR_INNER_LIM, ig.lim);
      // a write beyond the last register must change nothing
      stray_idx = CSR_IDX_W'($urandom_range(2**CSR_IDX_W - 1, int'(CSR_INNER_LIM) + 1));
      write_csr(stray_idx, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // all gains zero after reset, so both drives stay at zero
   task automatic test_reset_state();
      send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
      send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
   endtask

   // unity proportional gain with extreme errors drives both loops into the clamp
   task automatic test_output_saturation();
      reconfigure('{UNITY_GAIN, ZERO_GAIN, ZERO_GAIN, ZERO_LIM},
                  '{UNITY_GAIN, ZERO_GAIN, ZERO_GAIN, ZERO_LIM});
      send_sample(SAMPLE_MAX, SAMPLE_MIN, '0);
      send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
      send_sample('0, '0, '0);
      send_sample(-16'sd1, '0, SAMPLE_MIN);
   endtask

   // fractional results must round toward minus infinity
   task automatic test_floor_rounding();
      reconfigure('{HALF_GAIN, ZERO_GAIN, ZERO_GAIN, ZERO_LIM},
                  '{16'h0001, ZERO_GAIN, ZERO_GAIN, ZERO_LIM});
      send_sample(-16'sd1, '0, '0);
      send_sample(16'sd1, '0, '0);
      send_sample('0, 16'sd3, -16'sd5);
      send_sample(16'sd5, '0, 16'sd100);
   endtask

   // outer integral hits a small limit; inner has a zero limit, so its integral stays at zero
   task automatic test_integral_clamp();
      reconfigure('{ZERO_GAIN, MAX_GAIN, ZERO_GAIN, 23'h000300},
                  '{UNITY_GAIN, UNITY_GAIN, ZERO_GAIN, ZERO_LIM});
      repeat (3) send_sample(16'sd100, '0, '0);
      repeat (2) send_sample(-16'sd100, '0, '0);
   endtask

   // largest gains and limits with full-swing errors need the wide sums
   task automatic test_wide_products();
      reconfigure('{MAX_GAIN, MAX_GAIN, MAX_GAIN, MAX_LIM},
                  '{MAX_GAIN, MAX_GAIN, MAX_GAIN, MAX_LIM});
      send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN);
      send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
      send_sample('0, '0, '0);
   endtask

   // random traffic over several settings, the extremes among them
   task automatic test_random_traffic();
      loop_gains_type og;
      loop_gains_type ig;
      sample_type     target;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 0) begin
            og = '{MAX_GAIN, MAX_GAIN, MAX_GAIN, MAX_LIM};
            ig = og;
         end else if (p == 1) begin
            og = '{ZERO_GAIN, ZERO_GAIN, ZERO_GAIN, ZERO_LIM};
            ig = og;
         end else begin
            og = rand_loop();
            ig = rand_loop();
         end
         stall_on = (p % 3 != 2);
         reconfigure(og, ig);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off once per phase until the pipe is empty
            if (n == PHASE_ITEMS / 2) wait_results_drained();
            target = rand_sample();
            if ($urandom_range(2) == 0) send_sample(target, rand_sample(), rand_sample());
            else send_sample(target, near_sample(target), near_sample(target));
         end
      end
      stall_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls and in-order checking
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (stall_on && $urandom_range(3) == 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      drive_pair_type exp_pair;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            note_failure($sformatf("response with no request outstanding: drive %0d outer %0d",
                                   rsp_drive, rsp_outer_drive));
         end else begin
            exp_pair = expected_drives.pop_front();
            if (rsp_drive !== exp_pair.drive)
               note_failure($sformatf("drive expected %0d actual %0d",
                                      exp_pair.drive, rsp_drive));
            if (rsp_outer_drive !== exp_pair.outer_drive)
               note_failure($sformatf("outer_drive expected %0d actual %0d",
                                      exp_pair.outer_drive, rsp_outer_drive));
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding",
                  expected_drives.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_output_saturation();
      test_floor_rounding();
      test_integral_clamp();
      test_wide_products();
      test_random_traffic();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_drives.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
